// File: design/tun_pkg.sv
// tun_pkg: request and result types for the triangle unit normal block
// no dependencies
`default_nettype none
package tun_pkg;
  localparam int CoordW = 24;
  localparam int EdgeW = 25;
  localparam int CrossW = 51;
  localparam int MagW = 50;
  localparam int NormW = 30;
  localparam int SumW = 62;
  localparam int RootW = 31;
  localparam int QuoW = 45;
  localparam int DivW = 46;
  localparam int LenW = 32;
  localparam int FracOut = 14;
  localparam int UnitW = 16;
  localparam logic [UnitW-1:0] UnitOne = 16'd16384;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } req_t;

  typedef struct packed {
    logic signed [UnitW-1:0] unit_x;
    logic signed [UnitW-1:0] unit_y;
    logic signed [UnitW-1:0] unit_z;
    logic                    degenerate;
  } res_t;
endpackage
`default_nettype wire

// File: design/triangle_unit_normal.sv
// triangle_unit_normal: unit face normal of a triangle, pipelined
// depends on tun_pkg
//
//  channel | handshake          | payload
//  request | start_i, busy_o    | req_i  (tun_pkg::req_t)
//  result  | done_o (one cycle) | res_o  (tun_pkg::res_t)
//
// one triangle per clock; busy_o is always low
// path: front stages up to the squared length,
// square root, length rounding and dividends, divide, output
// square root one result bit per stage, the three divides one quotient bit per stage
// reset clears the valid bits only; results cannot be stalled
`default_nettype none
module triangle_unit_normal (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire tun_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output tun_pkg::res_t      res_o
);
  localparam int CW = tun_pkg::CrossW;
  localparam int MW = tun_pkg::MagW;
  localparam int NW = tun_pkg::NormW;
  localparam int SW = tun_pkg::SumW;
  localparam int RW = tun_pkg::RootW;
  localparam int QW = tun_pkg::QuoW;
  localparam int DW = tun_pkg::DivW;
  localparam int LenW = tun_pkg::LenW;

  assign busy_o = 1'b0;

  // stage 1: edges
  logic v1_q;
  logic signed [tun_pkg::EdgeW-1:0] e1_q [3];
  logic signed [tun_pkg::EdgeW-1:0] e2_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    e1_q[0] <= 25'(req_i.b_x) - 25'(req_i.a_x);
    e1_q[1] <= 25'(req_i.b_y) - 25'(req_i.a_y);
    e1_q[2] <= 25'(req_i.b_z) - 25'(req_i.a_z);
    e2_q[0] <= 25'(req_i.c_x) - 25'(req_i.a_x);
    e2_q[1] <= 25'(req_i.c_y) - 25'(req_i.a_y);
    e2_q[2] <= 25'(req_i.c_z) - 25'(req_i.a_z);
  end

  // stage 2: products
  logic v2_q;
  logic signed [49:0] pp_q [6];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    pp_q[0] <= e1_q[1] * e2_q[2];
    pp_q[1] <= e1_q[2] * e2_q[1];
    pp_q[2] <= e1_q[2] * e2_q[0];
    pp_q[3] <= e1_q[0] * e2_q[2];
    pp_q[4] <= e1_q[0] * e2_q[1];
    pp_q[5] <= e1_q[1] * e2_q[0];
  end

  // stage 3: cross, sign and magnitude
  logic v3_q;
  logic [MW-1:0] mag3_q [3];
  logic [2:0] neg3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [CW-1:0] c;
      c = CW'(pp_q[2*i]) - CW'(pp_q[2*i+1]);
      neg3_q[i] <= c[CW-1];
      mag3_q[i] <= c[CW-1] ? MW'(-c) : MW'(c);
    end
  end

  // stage 4: max magnitude
  logic v4_q;
  logic [MW-1:0] mag4_q [3];
  logic [MW-1:0] max4_q;
  logic [2:0] neg4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    logic [MW-1:0] m;
    m = (mag3_q[0] > mag3_q[1]) ? mag3_q[0] : mag3_q[1];
    max4_q <= (mag3_q[2] > m) ? mag3_q[2] : m;
    mag4_q <= mag3_q;
    neg4_q <= neg3_q;
  end

  // stage 5: bit length
  logic v5_q;
  logic [MW-1:0] mag5_q [3];
  logic [5:0] k5_q;
  logic deg5_q;
  logic [2:0] neg5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    logic [5:0] k;
    k = '0;
    for (int b = 0; b < MW; b++) if (max4_q[b]) k = 6'(b + 1);
    k5_q <= k;
    deg5_q <= (max4_q == '0);
    mag5_q <= mag4_q;
    neg5_q <= neg4_q;
  end

  // stage 6: normalize
  logic v6_q;
  logic [NW-1:0] nm6_q [3];
  logic deg6_q;
  logic [2:0] neg6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (k5_q < 6'(NW)) nm6_q[i] <= NW'(mag5_q[i] << (6'(NW) - k5_q));
      else nm6_q[i] <= NW'(mag5_q[i] >> (k5_q - 6'(NW)));
    end
    deg6_q <= deg5_q;
    neg6_q <= neg5_q;
  end

  // stage 7: squares
  logic v7_q;
  logic [2*NW-1:0] sq7_q [3];
  logic [NW-1:0] nm7_q [3];
  logic deg7_q;
  logic [2:0] neg7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) sq7_q[i] <= nm6_q[i] * nm6_q[i];
    nm7_q <= nm6_q;
    deg7_q <= deg6_q;
    neg7_q <= neg6_q;
  end

  // stage 8: sum
  logic v8_q;
  logic [SW-1:0] sum8_q;
  logic [NW-1:0] nm8_q [3];
  logic deg8_q;
  logic [2:0] neg8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    sum8_q <= SW'(sq7_q[0]) + SW'(sq7_q[1]) + SW'(sq7_q[2]);
    nm8_q <= nm7_q;
    deg8_q <= deg7_q;
    neg8_q <= neg7_q;
  end

  // square root, one result bit per stage
  typedef struct packed {
    logic deg;
    logic [2:0] neg;
    logic [SW+1:0] rem;
    logic [RW-1:0] root;
    logic [SW-1:0] rad;
    logic [3*NW-1:0] nm;
  } sq_t;

  function automatic sq_t sq_step(sq_t p);
    sq_t n;
    logic [SW+1:0] r;
    logic [SW+1:0] t;
    n = p;
    r = {p.rem[SW-1:0], p.rad[SW-1 -: 2]};
    t = {(SW-RW)'(0), p.root, 2'b01};
    if (r >= t) begin
      n.rem = r - t;
      n.root = {p.root[RW-2:0], 1'b1};
    end else begin
      n.rem = r;
      n.root = {p.root[RW-2:0], 1'b0};
    end
    n.rad = {p.rad[SW-3:0], 2'b00};
    return n;
  endfunction

  sq_t sq_in;
  sq_t sq_q [RW];
  logic [RW-1:0] sqv_q;
  always_comb begin
    sq_in.deg = deg8_q;
    sq_in.neg = neg8_q;
    sq_in.rem = '0;
    sq_in.root = '0;
    sq_in.rad = sum8_q;
    sq_in.nm = {nm8_q[2], nm8_q[1], nm8_q[0]};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sqv_q <= '0;
    else sqv_q <= {sqv_q[RW-2:0], v8_q};
  end
  always_ff @(posedge clk_i) begin
    sq_q[0] <= sq_step(sq_in);
    for (int s = 1; s < RW; s++) sq_q[s] <= sq_step(sq_q[s-1]);
  end

  // round length, form dividends
  logic vr_q;
  logic [LenW-1:0] len_q;
  logic [QW-1:0] dvd_q [3];
  logic degr_q;
  logic [2:0] negr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vr_q <= 1'b0;
    else vr_q <= sqv_q[RW-1];
  end
  always_ff @(posedge clk_i) begin
    logic [LenW-1:0] l;
    l = {1'b0, sq_q[RW-1].root};
    if (sq_q[RW-1].rem > (SW+2)'(sq_q[RW-1].root)) l = l + 1'b1;
    len_q <= (sq_q[RW-1].deg) ? LenW'(1) : l;
    for (int i = 0; i < 3; i++)
      dvd_q[i] <= QW'({sq_q[RW-1].nm[i*NW +: NW], 14'd0});
    degr_q <= sq_q[RW-1].deg;
    negr_q <= sq_q[RW-1].neg;
  end

  // add half length, then restoring divide, one quotient bit per stage
  typedef struct packed {
    logic deg;
    logic [2:0] neg;
    logic [LenW-1:0] len;
    logic [3*DW-1:0] rem;
    logic [3*QW-1:0] quo;
  } dv_t;

  function automatic dv_t dv_step(dv_t p);
    dv_t n;
    logic [DW-1:0] r;
    logic [QW-1:0] qq;
    n = p;
    for (int i = 0; i < 3; i++) begin
      qq = p.quo[i*QW +: QW];
      r = {p.rem[i*DW +: DW-1], qq[QW-1]};
      if (r >= DW'(p.len)) begin
        n.rem[i*DW +: DW] = r - DW'(p.len);
        n.quo[i*QW +: QW] = {qq[QW-2:0], 1'b1};
      end else begin
        n.rem[i*DW +: DW] = r;
        n.quo[i*QW +: QW] = {qq[QW-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  dv_t dv_in;
  dv_t dv_q [QW+1];
  logic [QW:0] dvv_q;
  always_comb begin
    dv_in.deg = degr_q;
    dv_in.neg = negr_q;
    dv_in.len = len_q;
    dv_in.rem = '0;
    for (int i = 0; i < 3; i++) dv_in.quo[i*QW +: QW] = dvd_q[i] + QW'(len_q >> 1);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dvv_q <= '0;
    else dvv_q <= {dvv_q[QW-1:0], vr_q};
  end
  always_ff @(posedge clk_i) begin
    dv_q[0] <= dv_in;
    for (int s = 0; s < QW; s++) dv_q[s+1] <= dv_step(dv_q[s]);
  end

  // clamp, sign, output
  logic done_q;
  tun_pkg::res_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= dvv_q[QW];
  end
  always_ff @(posedge clk_i) begin
    logic [tun_pkg::UnitW-1:0] u [3];
    logic [QW-1:0] qq;
    for (int i = 0; i < 3; i++) begin
      qq = dv_q[QW].quo[i*QW +: QW];
      u[i] = (qq > QW'(tun_pkg::UnitOne)) ? tun_pkg::UnitOne : qq[tun_pkg::UnitW-1:0];
      if (dv_q[QW].neg[i]) u[i] = -u[i];
      if (dv_q[QW].deg) u[i] = '0;
    end
    res_q.unit_x <= u[0];
    res_q.unit_y <= u[1];
    res_q.unit_z <= u[2];
    res_q.degenerate <= dv_q[QW].deg;
  end

  assign done_o = done_q;
  assign res_o = res_q;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.degenerate |-> res_o.unit_x == '0 && res_o.unit_y == '0
      && res_o.unit_z == '0) else $error("degenerate result not zero");
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o) else $error("busy raised");
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vr_q |=> dv_q[0].len != '0) else $error("zero divisor");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvv_q[QW] |=> done_o) else $error("result dropped");
`endif
endmodule
`default_nettype wire
